[rtl/assert_macros.svh]
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// implication with the consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

[rtl/lsnof_pkg.sv]
// package: types, constants and the arctangent table of the nearest object finder
`default_nettype none
package lsnof_pkg;
    localparam int MAX_CANDIDATES = 8192;
    localparam int GAP_LIMIT      = 5;
    localparam int CORDIC_GAIN    = 39797;
    localparam int BEST_RELOAD    = 5000;
    localparam int NONE_MARK      = 400000;
    localparam int CORDIC_STEPS   = 16;

    localparam logic [2:0] REG_ROBOT_X   = 3'd0;
    localparam logic [2:0] REG_ROBOT_Y   = 3'd1;
    localparam logic [2:0] REG_HEADING   = 3'd2;
    localparam logic [2:0] REG_MAX_RANGE = 3'd3;
    localparam logic [2:0] REG_MAX_WIDTH = 3'd4;
    localparam logic [2:0] REG_JUMP      = 3'd5;
    localparam logic [2:0] REG_TABLE_TOL = 3'd6;
    localparam logic [2:0] REG_BEACON_TOL = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHORD_TRIG,
        ST_CHORD_MUL,
        ST_CHORD_SUM,
        ST_CHORD_CMP,
        ST_POINT_TRIG,
        ST_POINT_MUL,
        ST_POINT_ADD,
        ST_FILTER,
        ST_FINISH,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic       sample_update;  // capture the incoming beat into the held registers
        logic       trig_start;     // load cordic
        logic       trig_sel_point; // 0: chord angle, 1: point angle
        logic       cordic_step;
        logic       chord_mul;
        logic       chord_sum;
        logic       chord_cmp;
        logic       point_mul;
        logic       point_add;
        logic       filter;
        logic       finish;         // segmentation update of the held beat, after any evaluation
        logic       load_result;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic evaluate;    // held beat closes an object
        logic is_last;
        logic cordic_done;
        logic chord_ok;
    } dp_status_t;

    function automatic logic [23:0] atan_unit(input logic [3:0] i);
        logic [23:0] v;
        begin
            case (i)
                4'd0:  v = 24'd2097152;
                4'd1:  v = 24'd1238021;
                4'd2:  v = 24'd654136;
                4'd3:  v = 24'd332050;
                4'd4:  v = 24'd166669;
                4'd5:  v = 24'd83416;
                4'd6:  v = 24'd41718;
                4'd7:  v = 24'd20860;
                4'd8:  v = 24'd10430;
                4'd9:  v = 24'd5215;
                4'd10: v = 24'd2608;
                4'd11: v = 24'd1304;
                4'd12: v = 24'd652;
                4'd13: v = 24'd326;
                4'd14: v = 24'd163;
                default: v = 24'd81;
            endcase
            atan_unit = v;
        end
    endfunction
endpackage
`default_nettype wire

[rtl/lsnof_ctrl.sv]
// controller state machine of the nearest object finder
`default_nettype none
module lsnof_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    input  wire lsnof_pkg::dp_status_t status,
    output lsnof_pkg::dp_cmd_t         cmd
);
    lsnof_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsnof_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // ST_IDLE also acts as the "beat held, decide" step: a beat is captured
    // in the datapath on accept and decoded while held_reg is set, still in ST_IDLE
    logic held_reg, held_next;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_reg <= 1'b0;
        else
            held_reg <= held_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        held_next      = held_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        unique case (state_reg)
            lsnof_pkg::ST_IDLE:
            begin
                if (held_reg)
                begin
                    if (status.evaluate)
                    begin
                        cmd.trig_start = 1'b1;
                        state_next     = lsnof_pkg::ST_CHORD_TRIG;
                    end
                    else
                        state_next = lsnof_pkg::ST_FINISH;
                end
                else
                begin
                    in_stall = 1'b0;
                    if (in_valid)
                    begin
                        cmd.sample_update = 1'b1;
                        held_next         = 1'b1;
                    end
                end
            end
            lsnof_pkg::ST_CHORD_TRIG:
            begin
                cmd.cordic_step = 1'b1;
                if (status.cordic_done)
                    state_next = lsnof_pkg::ST_CHORD_MUL;
            end
            lsnof_pkg::ST_CHORD_MUL:
            begin
                cmd.chord_mul = 1'b1;
                state_next    = lsnof_pkg::ST_CHORD_SUM;
            end
            lsnof_pkg::ST_CHORD_SUM:
            begin
                cmd.chord_sum = 1'b1;
                state_next    = lsnof_pkg::ST_CHORD_CMP;
            end
            lsnof_pkg::ST_CHORD_CMP:
            begin
                if (status.chord_ok)
                begin
                    cmd.chord_cmp      = 1'b1;
                    cmd.trig_start     = 1'b1;
                    cmd.trig_sel_point = 1'b1;
                    state_next         = lsnof_pkg::ST_POINT_TRIG;
                end
                else
                    state_next = lsnof_pkg::ST_FINISH;
            end
            lsnof_pkg::ST_POINT_TRIG:
            begin
                cmd.cordic_step = 1'b1;
                if (status.cordic_done)
                    state_next = lsnof_pkg::ST_POINT_MUL;
            end
            lsnof_pkg::ST_POINT_MUL:
            begin
                cmd.point_mul = 1'b1;
                state_next    = lsnof_pkg::ST_POINT_ADD;
            end
            lsnof_pkg::ST_POINT_ADD:
            begin
                cmd.point_add = 1'b1;
                state_next    = lsnof_pkg::ST_FILTER;
            end
            lsnof_pkg::ST_FILTER:
            begin
                cmd.filter = 1'b1;
                state_next = lsnof_pkg::ST_FINISH;
            end
            lsnof_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
                if (status.is_last)
                    state_next = lsnof_pkg::ST_OUT;
                else
                begin
                    held_next  = 1'b0;
                    state_next = lsnof_pkg::ST_IDLE;
                end
            end
            lsnof_pkg::ST_OUT:
            begin
                // wait for the output register to be free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    held_next       = 1'b0;
                    state_next      = lsnof_pkg::ST_IDLE;
                end
            end
            default:
                state_next = lsnof_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[rtl/lsnof_datapath.sv]
// datapath: segmentation registers, shared cordic, chord and table tests
`default_nettype none
module lsnof_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [15:0]         cfg_data,
    input  wire logic [15:0]         sample_bearing,
    input  wire logic [13:0]         sample_range,
    input  wire logic                last_sample,
    input  wire lsnof_pkg::dp_cmd_t  cmd,
    output lsnof_pkg::dp_status_t    status,
    output logic signed [19:0]       opponent_x,
    output logic signed [15:0]       opponent_y,
    output logic [18:0]              opponent_range,
    output logic [15:0]              opponent_bearing,
    output logic [13:0]              candidate_count,
    output logic                     found_this_scan
);
    // configuration
    logic signed [12:0] robot_x_reg, robot_y_reg;
    logic [15:0] heading_reg;
    logic [13:0] max_range_reg;
    logic [11:0] max_width_reg;
    logic [9:0]  jump_reg;
    logic [8:0]  table_tol_reg, beacon_tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            robot_x_reg    <= '0;
            robot_y_reg    <= '0;
            heading_reg    <= '0;
            max_range_reg  <= 14'd3600;
            max_width_reg  <= 12'd170;
            jump_reg       <= 10'd30;
            table_tol_reg  <= 9'd50;
            beacon_tol_reg <= 9'd100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lsnof_pkg::REG_ROBOT_X:    robot_x_reg    <= cfg_data[12:0];
                lsnof_pkg::REG_ROBOT_Y:    robot_y_reg    <= cfg_data[12:0];
                lsnof_pkg::REG_HEADING:    heading_reg    <= cfg_data;
                lsnof_pkg::REG_MAX_RANGE:  max_range_reg  <= cfg_data[13:0];
                lsnof_pkg::REG_MAX_WIDTH:  max_width_reg  <= cfg_data[11:0];
                lsnof_pkg::REG_JUMP:       jump_reg       <= cfg_data[9:0];
                lsnof_pkg::REG_TABLE_TOL:  table_tol_reg  <= cfg_data[8:0];
                default:                   beacon_tol_reg <= cfg_data[8:0];
            endcase
        end
    end

    // held beat
    logic [15:0] b_reg;
    logic [13:0] r_reg;
    logic        last_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.sample_update)
        begin
            b_reg    <= sample_bearing;
            r_reg    <= sample_range;
            last_reg <= last_sample;
        end
    end

    // segmentation state
    logic        in_obj_reg;
    logic [15:0] sb_reg, eb_reg;
    logic [13:0] sr_reg, er_reg;
    logic [2:0]  gap_reg;
    logic [13:0] cand_reg;
    logic [12:0] best_reg;
    logic        found_reg;
    logic signed [19:0] sox_reg;
    logic signed [15:0] soy_reg;
    logic [18:0] sor_reg;
    logic [15:0] sob_reg;

    // decode of the held beat
    logic in_win, nonzero, jump;
    logic [14:0] rdiff;
    logic [3:0]  gap_inc;
    logic        evaluate_w;
    assign in_win  = (r_reg > 14'd100) && (r_reg < max_range_reg);
    assign nonzero = (r_reg != '0);
    assign rdiff   = (er_reg >= r_reg) ? ({1'b0, er_reg} - {1'b0, r_reg})
                                       : ({1'b0, r_reg} - {1'b0, er_reg});
    assign jump    = rdiff > {5'd0, jump_reg};
    assign gap_inc = (gap_reg <= 3'(lsnof_pkg::GAP_LIMIT)) ? {1'b0, gap_reg} + 4'd1
                                                            : {1'b0, gap_reg};

    assign evaluate_w = in_win  ? (in_obj_reg && jump)
                      : nonzero ? in_obj_reg
                      : (in_obj_reg && (gap_inc > 4'(lsnof_pkg::GAP_LIMIT)));

    // shared cordic
    logic signed [18:0] cx_reg, cy_reg;
    logic signed [24:0] cz_reg;
    logic [3:0]  citer_reg;
    logic [1:0]  cq_reg;
    logic        cdone_reg;
    logic [15:0] ang;
    logic [15:0] mid_b;
    logic [13:0] mid_r;
    logic [16:0] bsum;
    logic [14:0] rsum;
    assign bsum  = {1'b0, sb_reg} + {1'b0, eb_reg};
    assign rsum  = {1'b0, sr_reg} + {1'b0, er_reg};
    assign mid_b = bsum[16:1];
    assign mid_r = rsum[14:1];
    assign ang   = cmd.trig_sel_point ? (heading_reg - mid_b) : (eb_reg - sb_reg);

    logic signed [24:0] atv;
    assign atv = 25'(lsnof_pkg::atan_unit(citer_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            citer_reg <= '0;
            cdone_reg <= 1'b0;
        end
        else if (cmd.trig_start)
        begin
            citer_reg <= '0;
            cdone_reg <= 1'b0;
        end
        else if (cmd.cordic_step)
        begin
            citer_reg <= citer_reg + 4'd1;
            cdone_reg <= (citer_reg == 4'(lsnof_pkg::CORDIC_STEPS - 1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.trig_start)
        begin
            cx_reg <= 19'(lsnof_pkg::CORDIC_GAIN);
            cy_reg <= '0;
            cz_reg <= {3'b000, ang[13:0], 8'd0};
            cq_reg <= ang[15:14];
        end
        else if (cmd.cordic_step && !cdone_reg)
        begin
            if (!cz_reg[24])
            begin
                cx_reg <= cx_reg - (cy_reg >>> citer_reg);
                cy_reg <= cy_reg + (cx_reg >>> citer_reg);
                cz_reg <= cz_reg - atv;
            end
            else
            begin
                cx_reg <= cx_reg + (cy_reg >>> citer_reg);
                cy_reg <= cy_reg - (cx_reg >>> citer_reg);
                cz_reg <= cz_reg + atv;
            end
        end
    end

    logic signed [18:0] cos_v, sin_v;
    always_comb
    begin
        case (cq_reg)
            2'd0:    begin cos_v = cx_reg;  sin_v = cy_reg;  end
            2'd1:    begin cos_v = -cy_reg; sin_v = cx_reg;  end
            2'd2:    begin cos_v = -cx_reg; sin_v = -cy_reg; end
            default: begin cos_v = cy_reg;  sin_v = -cx_reg; end
        endcase
    end

    // chord test
    logic [27:0] sq1_reg, sq2_reg, dd_reg;
    logic signed [47:0] ddc_reg;
    logic signed [46:0] lhs_reg;
    logic [23:0] w2;
    logic signed [33:0] dd_s;
    assign w2   = max_width_reg * max_width_reg;
    assign dd_s = {6'd0, dd_reg};
    always_ff @(posedge clk)
    begin
        if (cmd.chord_mul)
        begin
            sq1_reg <= sr_reg * sr_reg;
            sq2_reg <= er_reg * er_reg;
            dd_reg  <= sr_reg * er_reg;
        end
        if (cmd.chord_sum)
        begin
            ddc_reg <= 48'(dd_s * cos_v);
            lhs_reg <= 47'({18'd0, {1'b0, sq1_reg} + {1'b0, sq2_reg}} <<< 16);
        end
    end
    logic signed [48:0] s2;
    logic chord_ok_w;
    assign s2 = 49'(lhs_reg) - (49'(ddc_reg) <<< 1);
    assign chord_ok_w = s2 < $signed({9'd0, w2, 16'd0});

    // candidate point
    logic signed [34:0] px_reg, py_reg;
    logic signed [19:0] x_reg, y_reg;
    logic signed [15:0] mr_s;
    assign mr_s = {2'b00, mid_r};
    always_ff @(posedge clk)
    begin
        if (cmd.point_mul)
        begin
            px_reg <= 35'(mr_s * cos_v) + 35'sd32768;
            py_reg <= 35'(mr_s * sin_v) + 35'sd32768;
        end
        if (cmd.point_add)
        begin
            x_reg <= 20'(robot_x_reg) + 20'(px_reg >>> 16);
            y_reg <= 20'(robot_y_reg) + 20'(py_reg >>> 16);
        end
    end

    // table and beacon tests
    logic signed [20:0] xs, ys, tt, bt, ax, ay;
    logic on_table, near_x, beacon, better;
    assign xs = 21'(x_reg);
    assign ys = 21'(y_reg);
    assign tt = {12'd0, table_tol_reg};
    assign bt = {12'd0, beacon_tol_reg};
    assign ax = (xs >= 21'sd1000) ? xs - 21'sd1000 : 21'sd1000 - xs;
    assign ay = (ys >= 21'sd1500) ? ys - 21'sd1500 : 21'sd1500 - ys;
    assign on_table = (xs > -tt) && (xs < 21'sd2000 + tt) && (ys > -tt)
                   && (ys < 21'sd3000 + tt);
    assign near_x = (xs < bt) || (ax < bt) || (xs > 21'sd2000 - bt);
    assign beacon = ((ys < bt) && near_x) || ((ys > 21'sd3000 - bt) && near_x)
                 || ((ay < 21'sd500) && (xs < 21'sd180));
    assign better = {1'b0, mid_r} < {1'b0, best_reg};

    // segmentation and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_obj_reg <= 1'b0;
            sb_reg     <= '0;
            eb_reg     <= '0;
            sr_reg     <= '0;
            er_reg     <= '0;
            gap_reg    <= 3'd1;
            cand_reg   <= '0;
            best_reg   <= 13'(lsnof_pkg::BEST_RELOAD);
            found_reg  <= 1'b0;
            sox_reg    <= 20'(lsnof_pkg::NONE_MARK);
            soy_reg    <= '0;
            sor_reg    <= 19'(lsnof_pkg::NONE_MARK);
            sob_reg    <= '0;
        end
        else
        begin
            if (cmd.chord_cmp && cand_reg < 14'(lsnof_pkg::MAX_CANDIDATES))
                cand_reg <= cand_reg + 14'd1;
            if (cmd.filter && on_table && !beacon && better)
            begin
                sox_reg   <= x_reg;
                soy_reg   <= y_reg[15:0];
                sor_reg   <= {5'd0, mid_r};
                sob_reg   <= mid_b;
                // better implies mid_r below the 13 bit best distance
                best_reg  <= mid_r[12:0];
                found_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                if (last_reg)
                begin
                    in_obj_reg <= 1'b0;
                    sb_reg <= '0; eb_reg <= '0; sr_reg <= '0; er_reg <= '0;
                    gap_reg <= 3'd1;
                end
                else if (in_win)
                begin
                    in_obj_reg <= 1'b1;
                    if (!in_obj_reg || jump)
                    begin
                        sb_reg <= b_reg;
                        sr_reg <= r_reg;
                    end
                    eb_reg  <= b_reg;
                    er_reg  <= r_reg;
                    gap_reg <= 3'd1;
                end
                else if (nonzero)
                begin
                    if (in_obj_reg)
                    begin
                        in_obj_reg <= 1'b0;
                        sb_reg <= '0; eb_reg <= '0; sr_reg <= '0; er_reg <= '0;
                        gap_reg <= 3'd1;
                    end
                end
                else
                begin
                    if (in_obj_reg && gap_inc > 4'(lsnof_pkg::GAP_LIMIT))
                    begin
                        in_obj_reg <= 1'b0;
                        sb_reg <= '0; eb_reg <= '0; sr_reg <= '0; er_reg <= '0;
                        gap_reg <= 3'd1;
                    end
                    else
                        gap_reg <= gap_inc[2:0];
                end
            end
            if (cmd.load_result)
            begin
                cand_reg  <= '0;
                best_reg  <= 13'(lsnof_pkg::BEST_RELOAD);
                found_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            opponent_x       <= sox_reg;
            opponent_y       <= soy_reg;
            opponent_range   <= sor_reg;
            opponent_bearing <= sob_reg;
            candidate_count  <= cand_reg;
            found_this_scan  <= found_reg;
        end
    end

    // status back to the controller
    assign status = '{evaluate: evaluate_w, is_last: last_reg,
                      cordic_done: cdone_reg, chord_ok: chord_ok_w};
endmodule
`default_nettype wire

[rtl/lidar_scan_nearest_object_finder_unit.sv]
// top level of the lidar scan nearest object finder
// a beat is decided in ST_IDLE and then ends in ST_FINISH; a closing beat first runs the chord test and,
// if it passes, the point cordic pass and the filter; one beat is held at a time, in_stall high until it is finished
// the result beat follows the last sample of a scan; a stalled result holds the next last beat
// reset: asynchronous, active low; configuration, control and segmentation registers load their defaults
`default_nettype none
module lidar_scan_nearest_object_finder_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [15:0]        sample_bearing,
    input  wire logic [13:0]        sample_range,
    input  wire logic               last_sample,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [19:0]      opponent_x,
    output logic signed [15:0]      opponent_y,
    output logic [18:0]             opponent_range,
    output logic [15:0]             opponent_bearing,
    output logic [13:0]             candidate_count,
    output logic                    found_this_scan
);
    lsnof_pkg::dp_cmd_t    cmd;
    lsnof_pkg::dp_status_t status;

    // sequencing of each beat
    lsnof_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // segmentation, trig and filters
    lsnof_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .sample_bearing   (sample_bearing),
        .sample_range     (sample_range),
        .last_sample      (last_sample),
        .cmd              (cmd),
        .status           (status),
        .opponent_x       (opponent_x),
        .opponent_y       (opponent_y),
        .opponent_range   (opponent_range),
        .opponent_bearing (opponent_bearing),
        .candidate_count  (candidate_count),
        .found_this_scan  (found_this_scan)
    );
endmodule
`default_nettype wire

[rtl/lsnof_checker.sv]
// port level checker for the nearest object finder
`default_nettype none
`include "assert_macros.svh"
module lsnof_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [13:0] candidate_count,
    input wire logic        found_this_scan
);
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall,
        $stable(candidate_count) && $stable(found_this_scan))
    `ASSERT_NEXT(a_one_beat_in_flight, clk, rst_n, in_valid && !in_stall, in_stall)
    `ASSERT_IMPL(a_count_range, clk, rst_n, out_valid, candidate_count <= 14'd8192)
    `ASSERT_IMPL(a_found_count, clk, rst_n, out_valid && found_this_scan,
        candidate_count != 14'd0)
endmodule
bind lidar_scan_nearest_object_finder_unit lsnof_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .candidate_count(candidate_count), .found_this_scan(found_this_scan)
);
`default_nettype wire

[bench/tb_lidar_scan_nearest_object_finder_unit.sv]
// testbench for the lidar scan nearest object finder: directed table, random scans, scoreboard
`timescale 1ns / 1ps
module tb_lidar_scan_nearest_object_finder_unit;

    localparam int IDLE_LIMIT  = 3000;  // cycles with no accepted beat before giving up
    localparam int DRAIN_WAIT  = 80;    // covers the evaluation of a closing beat
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off for back pressure
    localparam int NUM_PHASES  = 8;
    localparam int RAND_PER_PHASE = 265;

    // one scan report as seen on the output port
    typedef struct packed {
        logic signed [19:0] x;
        logic signed [15:0] y;
        logic [18:0]        rng;
        logic [15:0]        brg;
        logic [13:0]        cnt;
        logic               found;
    } scan_report_t;

    typedef struct {
        logic [15:0]  brg;
        logic [13:0]  rng;
        logic         last;
        bit           typed;   // expected report written into the row
        scan_report_t rpt;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [15:0]        sample_bearing;
    logic [13:0]        sample_range;
    logic               last_sample;
    logic               out_valid;
    logic               out_stall;
    logic signed [19:0] opponent_x;
    logic signed [15:0] opponent_y;
    logic [18:0]        opponent_range;
    logic [15:0]        opponent_bearing;
    logic [13:0]        candidate_count;
    logic               found_this_scan;

    lidar_scan_nearest_object_finder_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sample_bearing   (sample_bearing),
        .sample_range     (sample_range),
        .last_sample      (last_sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .opponent_x       (opponent_x),
        .opponent_y       (opponent_y),
        .opponent_range   (opponent_range),
        .opponent_bearing (opponent_bearing),
        .candidate_count  (candidate_count),
        .found_this_scan  (found_this_scan)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // pending scan reports, oldest first
    scan_report_t report_q[$];

    int  err_count;
    int  n_samples;
    int  n_reports;
    int  n_found;
    int  idle_cycles;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_req;
    int  hold_left;

    // shadow of the configuration registers
    longint      cf_robot_x, cf_robot_y;
    int unsigned cf_heading, cf_max_range, cf_max_width, cf_jump, cf_table_tol, cf_beacon_tol;

    // shadow of the segmentation and per scan state
    bit          sh_in_object, sh_found;
    int unsigned sh_start_brg, sh_start_rng, sh_end_brg, sh_end_rng;
    int unsigned sh_gap, sh_candidates, sh_best;
    longint      sh_opp_x, sh_opp_y;
    int unsigned sh_opp_rng, sh_opp_brg;

    // 16 step cordic over the quadrant remainder, scaled by 65536
    function automatic void cordic_sincos(input int unsigned ang, output longint c,
                                          output longint s);
        longint x, y, z, dx, dy, atab[16];
        int unsigned q;
        atab = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
                 10430, 5215, 2608, 1304, 652, 326, 163, 81};
        q = (ang >> 14) & 3;
        z = longint'(ang & 16'h3FFF) * 256;
        x = lsnof_pkg::CORDIC_GAIN;
        y = 0;
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - atab[i];
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + atab[i];
            end
        end
        case (q)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic longint labs(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // close the open object: chord test, table mapping, beacon zones, nearest wins
    function automatic void close_object();
        longint d1, d2, c, s, chord2, w, x, y, tt, t;
        int unsigned mid_b, mid_r;
        bit near_x;
        d1 = sh_start_rng;
        d2 = sh_end_rng;
        cordic_sincos((sh_end_brg - sh_start_brg) & 16'hFFFF, c, s);
        chord2 = ((d1 * d1 + d2 * d2) * 65536) - 2 * d1 * d2 * c;
        w = cf_max_width;
        if (!(chord2 < w * w * 65536))
            return;
        if (sh_candidates < lsnof_pkg::MAX_CANDIDATES)
            sh_candidates++;
        mid_b = (sh_start_brg + sh_end_brg) >> 1;
        mid_r = (sh_start_rng + sh_end_rng) >> 1;
        cordic_sincos((cf_heading - mid_b) & 16'hFFFF, c, s);
        x = cf_robot_x + ((longint'(mid_r) * c + 32768) >>> 16);
        y = cf_robot_y + ((longint'(mid_r) * s + 32768) >>> 16);
        tt = cf_table_tol;
        if (!(x > -tt && x < 2000 + tt && y > -tt && y < 3000 + tt))
            return;
        t = cf_beacon_tol;
        near_x = x < t || labs(x - 1000) < t || x > 2000 - t;
        if ((y < t && near_x) || (y > 3000 - t && near_x) || (labs(y - 1500) < 500 && x < 180))
            return;
        if (mid_r < sh_best)
        begin
            sh_opp_x   = x;
            sh_opp_y   = y;
            sh_opp_rng = mid_r;
            sh_opp_brg = mid_b;
            sh_best    = mid_r;
            sh_found   = 1'b1;
        end
    endfunction

    function automatic void drop_object();
        sh_in_object = 1'b0;
        sh_start_brg = 0;
        sh_start_rng = 0;
        sh_end_brg   = 0;
        sh_end_rng   = 0;
        sh_gap       = 1;
    endfunction

    function automatic void shadow_reset();
        cf_robot_x = 0; cf_robot_y = 0; cf_heading = 0;
        cf_max_range = 3600; cf_max_width = 170; cf_jump = 30;
        cf_table_tol = 50; cf_beacon_tol = 100;
        drop_object();
        sh_candidates = 0;
        sh_best = lsnof_pkg::BEST_RELOAD;
        sh_found = 1'b0;
        sh_opp_x = lsnof_pkg::NONE_MARK;
        sh_opp_y = 0;
        sh_opp_rng = lsnof_pkg::NONE_MARK;
        sh_opp_brg = 0;
    endfunction

    // advance the shadow state by one sample; returns 1 with the report on a last sample
    function automatic bit track_sample(input logic [15:0] b, input logic [13:0] r,
                                        input logic last, output scan_report_t rpt);
        int unsigned bb, rr;
        bb = b;
        rr = r;
        rpt = '0;
        if (rr > 100 && rr < cf_max_range)
        begin
            if (!sh_in_object)
            begin
                sh_in_object = 1'b1;
                sh_start_brg = bb;
                sh_start_rng = rr;
            end
            else if (labs(longint'(sh_end_rng) - longint'(rr)) > longint'(cf_jump))
            begin
                close_object();
                sh_start_brg = bb;
                sh_start_rng = rr;
            end
            sh_end_brg = bb;
            sh_end_rng = rr;
            sh_gap = 1;
        end
        else if (rr != 0)
        begin
            if (sh_in_object)
            begin
                close_object();
                drop_object();
            end
        end
        else
        begin
            if (sh_gap <= lsnof_pkg::GAP_LIMIT)
                sh_gap++;
            if (sh_gap > lsnof_pkg::GAP_LIMIT && sh_in_object)
            begin
                close_object();
                drop_object();
            end
        end
        if (!last)
            return 1'b0;
        rpt.x     = sh_opp_x[19:0];
        rpt.y     = sh_opp_y[15:0];
        rpt.rng   = sh_opp_rng[18:0];
        rpt.brg   = sh_opp_brg[15:0];
        rpt.cnt   = sh_candidates[13:0];
        rpt.found = sh_found;
        drop_object();
        sh_candidates = 0;
        sh_best = lsnof_pkg::BEST_RELOAD;
        sh_found = 1'b0;
        return 1'b1;
    endfunction

    // register write at a falling edge, mirrored into the shadow
    task automatic write_reg(input logic [2:0] idx, input int val);
        logic [15:0] v;
        v = val[15:0];
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        case (idx)
            lsnof_pkg::REG_ROBOT_X:    cf_robot_x = longint'($signed(v[12:0]));
            lsnof_pkg::REG_ROBOT_Y:    cf_robot_y = longint'($signed(v[12:0]));
            lsnof_pkg::REG_HEADING:    cf_heading = v;
            lsnof_pkg::REG_MAX_RANGE:  cf_max_range = v[13:0];
            lsnof_pkg::REG_MAX_WIDTH:  cf_max_width = v[11:0];
            lsnof_pkg::REG_JUMP:       cf_jump = v[9:0];
            lsnof_pkg::REG_TABLE_TOL:  cf_table_tol = v[8:0];
            default:                   cf_beacon_tol = v[8:0];
        endcase
        @(negedge clk);
    endtask

    task automatic write_pose_and_limits(input int rx, input int ry, input int hd, input int mr,
                                         input int mw, input int jt, input int tt, input int bt);
        write_reg(lsnof_pkg::REG_ROBOT_X, rx);
        write_reg(lsnof_pkg::REG_ROBOT_Y, ry);
        write_reg(lsnof_pkg::REG_HEADING, hd);
        write_reg(lsnof_pkg::REG_MAX_RANGE, mr);
        write_reg(lsnof_pkg::REG_MAX_WIDTH, mw);
        write_reg(lsnof_pkg::REG_JUMP, jt);
        write_reg(lsnof_pkg::REG_TABLE_TOL, tt);
        write_reg(lsnof_pkg::REG_BEACON_TOL, bt);
        cfg_we <= 1'b0;
    endtask

    // offer one sample beat; valid stays high into the next call unless the sender idles
    task automatic send_sample(input logic [15:0] b, input logic [13:0] r, input logic last,
                               input bit typed, input scan_report_t typed_rpt);
        scan_report_t rpt;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        sample_bearing <= b;
        sample_range   <= r;
        last_sample    <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (track_sample(b, r, last, rpt))
            report_q.push_back(typed ? typed_rpt : rpt);
        n_samples++;
        @(negedge clk);
    endtask

    // quiet the sender and let every pending report and any open evaluation finish
    task automatic drain();
        in_valid <= 1'b0;
        while (report_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // one scan: narrow objects over a background of gaps and out of window returns, some noise
    task automatic random_scan(input int len, inout int budget);
        int unsigned brg, step, obj_rng, top, n, k;
        int pick;
        brg  = $urandom;
        step = $urandom_range(1, 40);
        top  = (cf_max_range > 151) ? cf_max_range - 1 : 151;
        k = 0;
        while (k < len && budget > 0)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                // object of a few samples with small range jitter
                obj_rng = $urandom_range(150, (top < 2200) ? top : 2200);
                n = $urandom_range(1, 12);
                for (int i = 0; i < n && k < len - 1; i++)
                begin
                    brg = brg + step;
                    send_sample(brg[15:0], 14'(obj_rng + $urandom_range(0, 20)), 1'b0, 0, '0);
                    k++; budget--;
                end
            end
            else if (pick < 65)
            begin
                // run of missing returns, sometimes past the gap limit
                n = $urandom_range(1, 8);
                for (int i = 0; i < n && k < len - 1; i++)
                begin
                    brg = brg + step;
                    send_sample(brg[15:0], 14'd0, 1'b0, 0, '0);
                    k++; budget--;
                end
            end
            else if (pick < 82)
            begin
                // out of window return: too near or too far
                brg = brg + step;
                send_sample(brg[15:0], 14'($urandom_range(1) ? $urandom_range(1, 100)
                            : $urandom_range(cf_max_range, 16383)), 1'b0, 0, '0);
                k++; budget--;
            end
            else
            begin
                // noise anywhere in the field ranges
                send_sample(16'($urandom_range(0, 65535)), 14'($urandom_range(0, 16383)),
                            1'b0, 0, '0);
                k++; budget--;
            end
            if (k >= len - 1 || budget <= 0)
            begin
                brg = brg + step;
                send_sample(brg[15:0], 14'(($urandom_range(3) == 0) ? 0
                            : $urandom_range(0, 16383)), 1'b1, 0, '0);
                k = len; budget--;
            end
        end
    endtask

    // scoreboard on the result channel
    always @(posedge clk)
    begin
        scan_report_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{opponent_x, opponent_y, opponent_range, opponent_bearing,
                    candidate_count, found_this_scan};
            n_reports++;
            if (found_this_scan)
                n_found++;
            if (report_q.size() == 0)
            begin
                $display("%0t: unexpected report beat %p", $time, got);
                err_count++;
            end
            else
            begin
                want = report_q.pop_front();
                if (got.x !== want.x)
                begin
                    $display("%0t: opponent_x exp %0d got %0d", $time, want.x, got.x);
                    err_count++;
                end
                if (got.y !== want.y)
                begin
                    $display("%0t: opponent_y exp %0d got %0d", $time, want.y, got.y);
                    err_count++;
                end
                if (got.rng !== want.rng)
                begin
                    $display("%0t: opponent_range exp %0d got %0d", $time, want.rng, got.rng);
                    err_count++;
                end
                if (got.brg !== want.brg)
                begin
                    $display("%0t: opponent_bearing exp %0d got %0d", $time, want.brg, got.brg);
                    err_count++;
                end
                if (got.cnt !== want.cnt)
                begin
                    $display("%0t: candidate_count exp %0d got %0d", $time, want.cnt, got.cnt);
                    err_count++;
                end
                if (got.found !== want.found)
                begin
                    $display("%0t: found_this_scan exp %0d got %0d", $time, want.found,
                             got.found);
                    err_count++;
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog: no accepted beat on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d reports pending", $time, report_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    stim_row_t dir_rows[$];
    scan_report_t none_rpt;

    initial
    begin
        int budget;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        sample_bearing = '0;
        sample_range = '0;
        last_sample = 1'b0;
        out_stall = 1'b0;
        err_count = 0;
        n_samples = 0;
        n_reports = 0;
        n_found = 0;
        idle_cycles = 0;
        hold_req = 1'b0;
        hold_left = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        shadow_reset();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // robot in the middle of the table facing along x
        write_pose_and_limits(1000, 1500, 0, 3600, 170, 30, 50, 100);

        // directed table; report after reset carries the "never found" marks
        none_rpt = '{20'sd400000, 16'sd0, 19'd400000, 16'd0, 14'd0, 1'b0};
        dir_rows = '{
            '{16'd0,     14'd0,     1'b1, 1, none_rpt},  // empty scan straight after reset
            '{16'd100,   14'd500,   1'b0, 0, '0},
            '{16'd104,   14'd502,   1'b0, 0, '0},
            '{16'd108,   14'd501,   1'b0, 0, '0},
            '{16'd110,   14'd0,     1'b0, 0, '0},        // five missing returns close it
            '{16'd112,   14'd0,     1'b0, 0, '0},
            '{16'd114,   14'd0,     1'b0, 0, '0},
            '{16'd116,   14'd0,     1'b0, 0, '0},
            '{16'd118,   14'd0,     1'b0, 0, '0},
            '{16'd200,   14'd16383, 1'b0, 0, '0},        // far return with nothing open
            '{16'd300,   14'd101,   1'b0, 0, '0},        // smallest range in the window
            '{16'd301,   14'd3599,  1'b0, 0, '0},        // jump splits the object
            '{16'd302,   14'd3600,  1'b0, 0, '0},        // range limit closes it
            '{16'd400,   14'd100,   1'b0, 0, '0},
            '{16'd65535, 14'd800,   1'b0, 0, '0},        // object across bearing wrap
            '{16'd2,     14'd800,   1'b0, 0, '0},
            '{16'd10,    14'd1,     1'b0, 0, '0},
            '{16'd1000,  14'd700,   1'b0, 0, '0},        // two objects at equal range
            '{16'd1002,  14'd700,   1'b0, 0, '0},
            '{16'd1010,  14'd5000,  1'b0, 0, '0},
            '{16'd1020,  14'd700,   1'b0, 0, '0},
            '{16'd1022,  14'd700,   1'b0, 0, '0},
            '{16'd1030,  14'd5000,  1'b0, 0, '0},
            '{16'd2000,  14'd900,   1'b0, 0, '0},        // still open at scan end
            '{16'd2002,  14'd900,   1'b1, 0, '0}
        };
        foreach (dir_rows[i])
            send_sample(dir_rows[i].brg, dir_rows[i].rng, dir_rows[i].last,
                        dir_rows[i].typed, dir_rows[i].rpt);
        drain();

        // random phases: idling pattern rotates, registers change between phases
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            if (ph == 2)
                write_pose_and_limits(-1000, 4000, 65535, 16383, 4000, 1000, 500, 500);
            else if (ph == 5)
                write_pose_and_limits(4000, -1000, 0, 0, 0, 0, 0, 0);
            else if (ph == 6)
                write_pose_and_limits(-4096, 4095, $urandom_range(0, 65535), 16383, 4095, 1023,
                                      511, 511);
            else
                write_pose_and_limits($urandom_range(300, 1700), $urandom_range(400, 2600),
                                      $urandom_range(0, 65535), $urandom_range(2500, 4000),
                                      $urandom_range(120, 500), $urandom_range(10, 80),
                                      $urandom_range(0, 100), $urandom_range(20, 150));
            // back pressure: receiver holds off while samples keep coming
            if (ph == 3)
                hold_req = 1'b1;
            budget = (ph == 5) ? 60 : RAND_PER_PHASE;
            while (budget > 0)
                random_scan($urandom_range(15, 50), budget);
            drain();
        end

        $display("covered %0d samples and %0d scan reports, %0d with a new opponent",
                 n_samples, n_reports, n_found);
        $display("register extremes, gap and jump closes, bearing wrap, stalls and long hold-off");
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
